/* src/npc_pkg.sv */
// Shared types, constants and helpers for the nearest palette color block.
// No dependencies; every other source file imports this package.
package npc_pkg;

    // Palette size and register file shape
    localparam int PALETTE_SIZE = 8;
    localparam int NUM_REGS     = 8;
    localparam int REG_IDX_W    = $clog2(NUM_REGS);
    localparam int REG_W        = 30;

    // Field widths
    localparam int PIX_W   = 16;
    localparam int CHAN_W  = 10;
    localparam int SQ_W    = 2 * CHAN_W;
    localparam int DIST_W  = 22;
    localparam int INDEX_W = 3;

    // Comparison tree has a fixed number of leaves; unused leaves are padded
    localparam int TREE_LEAVES = 8;

    // Pixel channel scale: floor(SCALE * v / 32) with five-bit channels
    localparam int SCALE      = 1000;
    localparam int PCHAN_W    = 5;
    localparam int SCALED_W   = 15;

    // Largest possible squared distance with ten-bit palette channels
    localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(3 * 1023 * 1023);

    // Reset palette: the eight corner colors
    localparam logic [REG_W-1:0] PALETTE_RESET [NUM_REGS] = '{
        30'd0,       30'd1048576000, 30'd1024000,    30'd1049600000,
        30'd1000,    30'd1048577000, 30'd1025000,    30'd1049601000
    };

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    // Scale a five-bit pixel channel onto the 0..1000 palette scale (results 0..968)
    function automatic logic [CHAN_W-1:0] scale_chan(input logic [PCHAN_W-1:0] v);
        logic [SCALED_W-1:0] prod;
        prod = SCALED_W'(v) * SCALED_W'(SCALE);
        return prod[SCALED_W-1:PCHAN_W];
    endfunction

    // Absolute difference of two channels
    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        if (a > b) begin
            d = a - b;
        end else begin
            d = b - a;
        end
        return d;
    endfunction

endpackage

/* src/nearest_palette_color.sv */
// Top level of the nearest palette color block: palette registers, input
// register, distance lanes and minimum tree. Depends on npc_pkg, npc_dist_lane,
// npc_min_tree.
//
// One RGB565 word is accepted on every cycle that i_start is high; o_busy is
// never raised. Each word yields one result, shown with o_valid for exactly one
// cycle, after the input register, difference register, distance register and
// three levels of the registered minimum tree. There is no backpressure, so
// results must be taken when strobed. Palette writes land at once and should
// only be made while no words are in flight.
module nearest_palette_color (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [npc_pkg::PIX_W-1:0]     i_pixel_color,
    output logic                          o_valid,
    output logic [npc_pkg::INDEX_W-1:0]   o_nearest_index,
    output logic [npc_pkg::DIST_W-1:0]    o_best_distance,
    input  logic                          i_cfg_wr_en,
    input  logic [npc_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [npc_pkg::REG_W-1:0]     i_cfg_data
);
    import npc_pkg::*;

    localparam int LATENCY = 6;

    logic [REG_W-1:0]  r_palette [NUM_REGS];
    t_rgb              r_pix, n_pix;
    logic              r_in_valid, r_diff_valid, r_dist_valid;
    logic [DIST_W-1:0] w_dist [PALETTE_SIZE];

    assign o_busy = 1'b0;

    // Write palette registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette <= PALETTE_RESET;
        end else if (i_cfg_wr_en) begin
            r_palette[i_cfg_index] <= i_cfg_data;
        end
    end

    // Scale pixel channels; green drops its low bit
    always_comb begin
        n_pix.red   = scale_chan(i_pixel_color[15:11]);
        n_pix.green = scale_chan(i_pixel_color[10:6]);
        n_pix.blue  = scale_chan(i_pixel_color[4:0]);
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end

    // Advance valid through the input and lane stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_diff_valid <= 1'b0;
            r_dist_valid <= 1'b0;
        end else begin
            r_in_valid   <= i_start && !o_busy;
            r_diff_valid <= r_in_valid;
            r_dist_valid <= r_diff_valid;
        end
    end

    // One distance lane per palette entry
    for (genvar g = 0; g < PALETTE_SIZE; g++) begin : g_lane
        npc_dist_lane u_lane (
            .i_clk      (i_clk),
            .i_pix      (r_pix),
            .i_entry    (r_palette[g]),
            .o_distance (w_dist[g])
        );
    end

    npc_min_tree u_tree (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_dist_valid),
        .i_dist     (w_dist),
        .o_valid    (o_valid),
        .o_index    (o_nearest_index),
        .o_distance (o_best_distance)
    );

    // Every accepted word gives a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##LATENCY o_valid)
        else $error("result missing after accepted word");

    // No result without a word accepted earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LATENCY))
        else $error("result without accepted word");

    // Block never stalls the source
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");

endmodule

/* src/npc_dist_lane.sv */
// One distance lane: channel differences, then squared Euclidean distance.
// Depends on npc_pkg. Two register stages, pure datapath.
module npc_dist_lane (
    input  logic                       i_clk,
    input  npc_pkg::t_rgb              i_pix,
    input  logic [npc_pkg::REG_W-1:0]  i_entry,
    output logic [npc_pkg::DIST_W-1:0] o_distance
);
    import npc_pkg::*;

    logic [CHAN_W-1:0] r_diff_r, r_diff_g, r_diff_b;
    logic [CHAN_W-1:0] n_diff_r, n_diff_g, n_diff_b;
    logic [SQ_W-1:0]   w_sq_r, w_sq_g, w_sq_b;
    logic [DIST_W-1:0] r_dist, n_dist;

    // Unpack the entry and take channel differences
    always_comb begin
        n_diff_r = abs_diff(i_entry[3*CHAN_W-1:2*CHAN_W], i_pix.red);
        n_diff_g = abs_diff(i_entry[2*CHAN_W-1:CHAN_W],   i_pix.green);
        n_diff_b = abs_diff(i_entry[CHAN_W-1:0],          i_pix.blue);
    end

    always_ff @(posedge i_clk) begin
        r_diff_r <= n_diff_r;
        r_diff_g <= n_diff_g;
        r_diff_b <= n_diff_b;
    end

    // Square each difference and sum
    always_comb begin
        w_sq_r = SQ_W'(r_diff_r) * SQ_W'(r_diff_r);
        w_sq_g = SQ_W'(r_diff_g) * SQ_W'(r_diff_g);
        w_sq_b = SQ_W'(r_diff_b) * SQ_W'(r_diff_b);
        n_dist = DIST_W'(w_sq_r) + DIST_W'(w_sq_g) + DIST_W'(w_sq_b);
    end

    always_ff @(posedge i_clk) begin
        r_dist <= n_dist;
    end

    assign o_distance = r_dist;

endmodule

/* src/npc_min_tree.sv */
// Registered three-level minimum tree over the lane distances.
// Depends on npc_pkg. Lower index wins on equal distances.
module npc_min_tree (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [npc_pkg::DIST_W-1:0]  i_dist [npc_pkg::PALETTE_SIZE],
    output logic                        o_valid,
    output logic [npc_pkg::INDEX_W-1:0] o_index,
    output logic [npc_pkg::DIST_W-1:0]  o_distance
);
    import npc_pkg::*;

    localparam int L1_N = TREE_LEAVES / 2;
    localparam int L2_N = TREE_LEAVES / 4;

    logic [DIST_W-1:0]  w_leaf_d [TREE_LEAVES];
    logic [DIST_W-1:0]  r_l1_d [L1_N], n_l1_d [L1_N];
    logic [INDEX_W-1:0] r_l1_i [L1_N], n_l1_i [L1_N];
    logic [DIST_W-1:0]  r_l2_d [L2_N], n_l2_d [L2_N];
    logic [INDEX_W-1:0] r_l2_i [L2_N], n_l2_i [L2_N];
    logic [DIST_W-1:0]  r_out_d, n_out_d;
    logic [INDEX_W-1:0] r_out_i, n_out_i;
    logic               r_l1_v, r_l2_v, r_out_v;

    // Pad unused leaves with a distance no real entry can reach
    always_comb begin
        for (int k = 0; k < TREE_LEAVES; k++) begin
            if (k < PALETTE_SIZE) begin
                w_leaf_d[k] = i_dist[k];
            end else begin
                w_leaf_d[k] = '1;
            end
        end
    end

    // First level: pairs of leaves
    always_comb begin
        for (int k = 0; k < L1_N; k++) begin
            if (w_leaf_d[2*k+1] < w_leaf_d[2*k]) begin
                n_l1_d[k] = w_leaf_d[2*k+1];
                n_l1_i[k] = INDEX_W'(2*k+1);
            end else begin
                n_l1_d[k] = w_leaf_d[2*k];
                n_l1_i[k] = INDEX_W'(2*k);
            end
        end
    end

    // Second level
    always_comb begin
        for (int k = 0; k < L2_N; k++) begin
            if (r_l1_d[2*k+1] < r_l1_d[2*k]) begin
                n_l2_d[k] = r_l1_d[2*k+1];
                n_l2_i[k] = r_l1_i[2*k+1];
            end else begin
                n_l2_d[k] = r_l1_d[2*k];
                n_l2_i[k] = r_l1_i[2*k];
            end
        end
    end

    // Final level
    always_comb begin
        if (r_l2_d[1] < r_l2_d[0]) begin
            n_out_d = r_l2_d[1];
            n_out_i = r_l2_i[1];
        end else begin
            n_out_d = r_l2_d[0];
            n_out_i = r_l2_i[0];
        end
    end

    // Hold payload per level
    always_ff @(posedge i_clk) begin
        r_l1_d  <= n_l1_d;
        r_l1_i  <= n_l1_i;
        r_l2_d  <= n_l2_d;
        r_l2_i  <= n_l2_i;
        r_out_d <= n_out_d;
        r_out_i <= n_out_i;
    end

    // Advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_v  <= 1'b0;
            r_l2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_l1_v  <= i_valid;
            r_l2_v  <= r_l1_v;
            r_out_v <= r_l2_v;
        end
    end

    assign o_valid    = r_out_v;
    assign o_index    = r_out_i;
    assign o_distance = r_out_d;

    // First-level winner of leaves 0 and 1 never exceeds the distance of either leaf
    a_l1_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_l1_v |-> (r_l1_d[0] <= $past(w_leaf_d[0]) && r_l1_d[0] <= $past(w_leaf_d[1])))
        else $error("level one minimum wrong");

    // Chosen index always refers to a real palette entry
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (32'(r_out_i) < PALETTE_SIZE))
        else $error("index beyond palette");

    // Result distance fits the physical range
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_d <= MAX_DIST))
        else $error("distance out of range");

endmodule

/* verif/nearest_palette_color_tb.sv */
// Self-checking testbench for nearest_palette_color: drives RGB565 words and
// palette writes, predicts each nearest entry and distance, checks each result.
// Depends on npc_pkg and the nearest_palette_color RTL.
module nearest_palette_color_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import npc_pkg::*;

    // Cycles from an accepted word to its result strobe
    localparam int PIPE_DEPTH = 6;
    localparam int RAND_WORDS = 2000;
    localparam int RAND_PHASES = 8;
    localparam int MAX_PRINTS = 100;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic [DIST_W-1:0]  best_dist;
    } t_match;

    // Palette copy, expected matches and the mismatch count
    class nearest_color_board;
        t_rgb        palette_copy [NUM_REGS];
        t_match      pending_matches [$];
        int unsigned errors;

        function new();
            foreach (palette_copy[i]) palette_copy[i] = t_rgb'(PALETTE_RESET[i]);
            errors = 0;
        endfunction

        function void set_entry(int idx, logic [REG_W-1:0] value);
            palette_copy[idx] = t_rgb'(value);
        endfunction

        function int unsigned chan_gap_sq(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
            int unsigned gap;
            gap = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
            return gap * gap;
        endfunction

        // Scan entries upward; strict less-than keeps the lowest index on ties
        function t_match closest_entry(logic [PIX_W-1:0] px);
            logic [CHAN_W-1:0] pr, pg, pb;
            int unsigned       d, best_d;
            int                n, best;
            t_match            m;
            pr = CHAN_W'(SCALE * int'(px[15:11]) / 32);
            pg = CHAN_W'(SCALE * int'(px[10:6]) / 32);
            pb = CHAN_W'(SCALE * int'(px[4:0]) / 32);
            n = PALETTE_SIZE;
            if (n > NUM_REGS) n = NUM_REGS;
            if (n < 1) n = 1;
            best = 0;
            best_d = 0;
            for (int i = 0; i < n; i++) begin
                d = chan_gap_sq(palette_copy[i].red, pr)
                  + chan_gap_sq(palette_copy[i].green, pg)
                  + chan_gap_sq(palette_copy[i].blue, pb);
                if (i == 0 || d < best_d) begin
                    best = i;
                    best_d = d;
                end
            end
            m.index     = INDEX_W'(best);
            m.best_dist = DIST_W'(best_d);
            return m;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px);
            pending_matches.push_back(closest_entry(px));
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTS) $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [INDEX_W-1:0] index, logic [DIST_W-1:0] distance);
            t_match want;
            if (pending_matches.size() == 0) begin
                report_mismatch($sformatf("unexpected result index %0d dist %0d",
                                          index, distance));
            end else begin
                want = pending_matches.pop_front();
                if (index !== want.index)
                    report_mismatch($sformatf("nearest_index %0d, want %0d",
                                              index, want.index));
                if (distance !== want.best_dist)
                    report_mismatch($sformatf("best_distance %0d, want %0d",
                                              distance, want.best_dist));
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic [PIX_W-1:0]     i_pixel_color = '0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] i_cfg_index = '0;
    logic [REG_W-1:0]     i_cfg_data = '0;
    logic                 o_busy;
    logic                 o_valid;
    logic [INDEX_W-1:0]   o_nearest_index;
    logic [DIST_W-1:0]    o_best_distance;

    nearest_color_board board = new();

    nearest_palette_color u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_pixel_color   (i_pixel_color),
        .o_valid         (o_valid),
        .o_nearest_index (o_nearest_index),
        .o_best_distance (o_best_distance),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Check strobed results, then note the word taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) board.check_result(o_nearest_index, o_best_distance);
            if (i_start && !o_busy) board.note_pixel(i_pixel_color);
        end
    end

    function automatic logic [REG_W-1:0] pack_rgb(int r, int g, int b);
        return {CHAN_W'(r), CHAN_W'(g), CHAN_W'(b)};
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Hold the word until taken, then idle for the given gap
    task automatic send_pixel(input logic [PIX_W-1:0] px, input int unsigned gap);
        i_start <= 1'b1;
        i_pixel_color <= px;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (gap != 0) begin
            i_start <= 1'b0;
            i_pixel_color <= PIX_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait for every expected result plus the pipe depth
    task automatic drain_pipeline();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (board.pending_matches.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    // Write all eight entries back to back; block must be idle
    task automatic load_palette(input logic [REG_W-1:0] entries [NUM_REGS]);
        int i;
        for (i = 0; i < NUM_REGS; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= REG_IDX_W'(i);
            i_cfg_data  <= entries[i];
            board.set_entry(i, entries[i]);
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        i_cfg_data  <= REG_W'($urandom);
    endtask

    // Build a palette for one random phase
    task automatic make_palette(input int mode, output logic [REG_W-1:0] entries [NUM_REGS]);
        logic [REG_W-1:0] same;
        int i;
        same = pack_rgb($urandom_range(0, 1000), $urandom_range(0, 1000),
                        $urandom_range(0, 1000));
        for (i = 0; i < NUM_REGS; i++) begin
            case (mode)
                0: begin
                    entries[i] = PALETTE_RESET[i];
                end
                1: begin
                    entries[i] = pack_rgb($urandom_range(0, 1000), $urandom_range(0, 1000),
                                          $urandom_range(0, 1000));
                end
                2: begin
                    entries[i] = REG_W'($urandom);
                end
                3: begin
                    // identical entries: every word ties
                    entries[i] = same;
                end
                4: begin
                    entries[i] = (i % 2 == 0) ? '1 : '0;
                end
                default: begin
                    // few distinct entries, so ties show up on random words
                    entries[i] = pack_rgb(500 * $urandom_range(0, 2), 500 * $urandom_range(0, 2),
                                          500 * $urandom_range(0, 2));
                end
            endcase
        end
    endtask

    // Random words; a burst phase runs with no gaps
    task automatic run_random(input int count, input bit burst);
        logic [PIX_W-1:0] px;
        int k;
        for (k = 0; k < count; k++) begin
            px = PIX_W'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                // channels pinned to their ends
                px = {{5{px[15]}}, {6{px[10]}}, {5{px[4]}}};
            end
            send_pixel(px, burst ? 0 : pick_gap());
            if ($urandom_range(0, 199) == 0) drain_pipeline();
        end
    endtask

    initial begin
        logic [REG_W-1:0] entries [NUM_REGS];
        logic [PIX_W-1:0] directed [$];
        int p;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset palette: black, white, primaries, secondaries, dropped green bit, grey
        // that ties on all eight corners
        directed = '{16'h0000, 16'hFFFF, 16'h0020, 16'hFFDF, 16'hF800, 16'h07C0,
                     16'h001F, 16'h8410, 16'hF81F, 16'h07FF, 16'hFFE0, 16'h7BEF};
        foreach (directed[i]) send_pixel(directed[i], i % 3);
        drain_pipeline();

        // Channels above 1000 and duplicated entries
        entries = '{'1, '0, '0, pack_rgb(1023, 0, 1023), pack_rgb(1000, 1000, 1000),
                    pack_rgb(0, 1023, 0), pack_rgb(1023, 1023, 0), pack_rgb(1000, 1000, 1000)};
        load_palette(entries);
        directed = '{16'h0000, 16'hFFFF, 16'hF81F, 16'h07E0, 16'hFFE0, 16'hFFDF,
                     16'h8410, 16'h0020};
        foreach (directed[i]) send_pixel(directed[i], 0);
        drain_pipeline();

        for (p = 0; p < RAND_PHASES; p++) begin
            make_palette((p == RAND_PHASES - 1) ? 0 : (p + 1) % 6, entries);
            load_palette(entries);
            run_random(RAND_WORDS / RAND_PHASES, p % 3 == 2);
            drain_pipeline();
        end

        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
